FILE: rtl/adcac_pkg.sv
`timescale 1ns / 1ps
package adcac_pkg;

    // channel order on the stream
    localparam int CHANNELS   = 5;
    localparam int CH_CV      = 0;
    localparam int CH_BV      = 1;
    localparam int CH_IC      = 2;
    localparam int CH_LA      = 3;
    localparam int CH_LB      = 4;

    localparam int WINDOW_LEN_DEF = 8;

    // field widths
    localparam int SAMPLE_W   = 10;
    localparam int SUM_W      = 16;
    localparam int VAL_W      = 13;
    localparam int ACC_W      = 32;
    localparam int GAIN_W     = 19;
    localparam int DROP_W     = 25;
    localparam int IN_W       = 56;
    localparam int OUT_W      = 64;

    // apb
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // q16.16 calibration constants
    localparam logic [GAIN_W-1:0]       K_CV_GAIN = 19'd105408;
    localparam logic signed [ACC_W-1:0] K_CV_OFS  = 32'sd95951;
    localparam logic [GAIN_W-1:0]       K_BV_GAIN = 19'd105677;
    localparam logic signed [ACC_W-1:0] K_BV_OFS  = -32'sd566998;
    localparam logic [GAIN_W-1:0]       K_IC_GAIN = 19'd342799;
    localparam logic signed [ACC_W-1:0] K_IC_OFS  = 32'sd4084924;
    localparam logic [GAIN_W-1:0]       K_LC_GAIN = 19'd73263;
    localparam logic signed [ACC_W-1:0] K_LC_OFS  = 32'sd4863951;
    localparam logic [11:0]             K_DROP    = 12'd3080;

    localparam logic [VAL_W-1:0] MAX_12 = 13'd4095;
    localparam logic [VAL_W-1:0] MAX_13 = 13'd8191;
    localparam logic [VAL_W-1:0] MAX_11 = 13'd2047;

    // register map, word index
    typedef enum logic [1:0] {
        REG_CV_OFS   = 2'd0,
        REG_BV_OFS   = 2'd1,
        REG_IC_FLOOR = 2'd2,
        REG_LC_FLOOR = 2'd3
    } reg_idx_t;

    // per-lane calibration behavior
    typedef struct packed {
        logic [GAIN_W-1:0]       gain;
        logic signed [ACC_W-1:0] ofs;
        logic                    use_floor;
        logic                    zero_on_zero;
        logic [VAL_W-1:0]        max_val;
    } lane_mode_t;

    localparam lane_mode_t LANE_MODES [CHANNELS] = '{
        '{gain: K_CV_GAIN, ofs: K_CV_OFS, use_floor: 1'b0, zero_on_zero: 1'b0,
          max_val: MAX_12},
        '{gain: K_BV_GAIN, ofs: K_BV_OFS, use_floor: 1'b0, zero_on_zero: 1'b1,
          max_val: MAX_12},
        '{gain: K_IC_GAIN, ofs: K_IC_OFS, use_floor: 1'b1, zero_on_zero: 1'b0,
          max_val: MAX_13},
        '{gain: K_LC_GAIN, ofs: K_LC_OFS, use_floor: 1'b1, zero_on_zero: 1'b0,
          max_val: MAX_11},
        '{gain: K_LC_GAIN, ofs: K_LC_OFS, use_floor: 1'b1, zero_on_zero: 1'b0,
          max_val: MAX_11}
    };

    // pipeline control handed to each lane
    typedef struct packed {
        logic adv;
        logic accept;
    } stage_ctrl_t;

    // result word, calibrated charger voltage in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [10:0] lamp_current_b;
        logic [10:0] lamp_current_a;
        logic [12:0] charge_current;
        logic [11:0] battery_volt;
        logic [11:0] charger_volt;
    } result_t;

    // integer part of a q16.16 value, clamped to [0, maxv]
    function automatic logic [VAL_W-1:0] clamp_q16(logic signed [ACC_W-1:0] acc,
                                                   logic [VAL_W-1:0] maxv);
        logic [14:0]      ip;
        logic [VAL_W-1:0] res;
        ip = acc[30:16];
        if (acc[ACC_W-1])
            res = '0;
        else if (ip > {2'b00, maxv})
            res = maxv;
        else
            res = ip[VAL_W-1:0];
        return res;
    endfunction

endpackage

FILE: rtl/adcac_lane.sv
`timescale 1ns / 1ps
module adcac_lane #(
    parameter int                  WINDOW_LEN = adcac_pkg::WINDOW_LEN_DEF,
    parameter adcac_pkg::lane_mode_t LANE_MODE = adcac_pkg::LANE_MODES[0]
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  adcac_pkg::stage_ctrl_t                 ctrl,
    input  logic [adcac_pkg::SAMPLE_W-1:0]         sample,
    input  logic signed [adcac_pkg::SAMPLE_W-1:0]  cfg_offset,
    input  logic [adcac_pkg::SAMPLE_W-1:0]         cfg_floor,
    output logic [adcac_pkg::VAL_W-1:0]            value
);
    import adcac_pkg::*;

    // exact floor division by the window length through a rounded-up reciprocal
    localparam int     LOG_N    = $clog2(WINDOW_LEN);
    localparam int     RSHIFT   = SUM_W + LOG_N;
    localparam int     RECIP_W  = RSHIFT + 1;
    localparam longint RECIP_L  = ((longint'(1) << RSHIFT) + longint'(WINDOW_LEN) - 1)
                                  / longint'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int     PROD_W   = SUM_W + RECIP_W;

    logic [SAMPLE_W-1:0]     hist_reg [WINDOW_LEN];
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;

    logic [PROD_W-1:0]       div_prod;
    logic [SAMPLE_W-1:0]     mean_reg;

    logic [28:0]             cal_prod;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    pass_reg;
    logic                    zero_reg;
    logic [SAMPLE_W-1:0]     mean_d_reg;

    logic [VAL_W-1:0]        value_next;
    logic [VAL_W-1:0]        value_reg;

    // running sum: oldest sample leaves as the new one enters
    assign sum_next = sum_reg - SUM_W'(hist_reg[WINDOW_LEN-1]) + SUM_W'(sample);

    // window shift line and sum, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
                hist_reg[i] <= '0;
            sum_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i < WINDOW_LEN; i++)
                hist_reg[i] <= hist_reg[i-1];
            sum_reg <= sum_next;
        end
    end

    // window mean
    assign div_prod = PROD_W'(sum_reg) * PROD_W'(RECIP);

    // gain and offsets in q16.16
    assign cal_prod = 29'(mean_reg) * 29'(LANE_MODE.gain);
    assign acc_next = signed'({3'b000, cal_prod}) + LANE_MODE.ofs
                    + signed'({{6{cfg_offset[SAMPLE_W-1]}}, cfg_offset, 16'h0000});

    // select calibrated, raw or zero
    always_comb
    begin
        if (zero_reg)
            value_next = '0;
        else if (pass_reg)
            value_next = VAL_W'(mean_d_reg);
        else
            value_next = clamp_q16(acc_reg, LANE_MODE.max_val);
    end

    // pipeline stages, advancing with the whole block
    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            mean_reg   <= div_prod[RSHIFT +: SAMPLE_W];
            acc_reg    <= acc_next;
            pass_reg   <= LANE_MODE.use_floor && (mean_reg < cfg_floor);
            zero_reg   <= LANE_MODE.zero_on_zero && (mean_reg == '0);
            mean_d_reg <= mean_reg;
            value_reg  <= value_next;
        end
    end

    assign value = value_reg;

endmodule

FILE: rtl/adcac_merge.sv
`timescale 1ns / 1ps
module adcac_merge (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [adcac_pkg::VAL_W-1:0]  lane_val [adcac_pkg::CHANNELS],
    output adcac_pkg::result_t           result
);
    import adcac_pkg::*;

    logic [DROP_W-1:0]       drop_reg;
    logic [11:0]             vb_reg;
    logic [11:0]             cv_reg;
    logic [12:0]             ic_reg;
    logic [10:0]             la_reg;
    logic [10:0]             lb_reg;
    logic signed [ACC_W-1:0] bv_diff;
    logic [VAL_W-1:0]        bv_val;
    result_t                 result_reg;

    // battery voltage less the drop across the charger current path
    assign bv_diff = signed'({4'b0000, vb_reg, 16'h0000}) - signed'({7'b0, drop_reg});
    assign bv_val  = clamp_q16(bv_diff, MAX_12);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drop_reg <= DROP_W'(lane_val[CH_IC]) * DROP_W'(K_DROP);
            vb_reg   <= lane_val[CH_BV][11:0];
            cv_reg   <= lane_val[CH_CV][11:0];
            ic_reg   <= lane_val[CH_IC];
            la_reg   <= lane_val[CH_LA][10:0];
            lb_reg   <= lane_val[CH_LB][10:0];

            result_reg.pad            <= '0;
            result_reg.charger_volt   <= cv_reg;
            result_reg.battery_volt   <= bv_val[11:0];
            result_reg.charge_current <= ic_reg;
            result_reg.lamp_current_a <= la_reg;
            result_reg.lamp_current_b <= lb_reg;
        end
    end

    assign result = result_reg;

endmodule

FILE: rtl/adc_average_and_calibrate_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  five 10-bit samples in s_tdata
// m_*       out  m_tvalid/m_tready  five calibrated values in m_tdata
// apb       in   psel/penable       four 10-bit registers at 0x0, 0x4, 0x8, 0xc
//
// one sample set per cycle while m_tready does not stall; m_tvalid rises once a set has passed
// the registers for running sum, mean multiply, gain multiply, clamp, drop multiply and output
// rst_n clears the sample windows, the sums, the valid bits and the config registers
// a stall on m_tready freezes the whole pipeline and drops s_tready
module adc_average_and_calibrate_core #(
    parameter int WINDOW_LEN = adcac_pkg::WINDOW_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // raw_charger_volt, raw_battery_volt, raw_charge_current,
    // raw_lamp_current_a, raw_lamp_current_b (10 bits each), zero fill
    input  logic [adcac_pkg::IN_W-1:0]     s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // charger_volt (12), battery_volt (12), charge_current (13),
    // lamp_current_a (11), lamp_current_b (11), zero fill
    output logic [adcac_pkg::OUT_W-1:0]    m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [adcac_pkg::ADDR_W-1:0]   paddr,
    input  logic [adcac_pkg::DATA_W-1:0]   pwdata,
    output logic [adcac_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import adcac_pkg::*;

    localparam int STAGES = 5;

    logic [SAMPLE_W-1:0]        cv_ofs_reg;
    logic [SAMPLE_W-1:0]        bv_ofs_reg;
    logic [SAMPLE_W-1:0]        ic_floor_reg;
    logic [SAMPLE_W-1:0]        lc_floor_reg;
    logic                       cfg_wr;
    reg_idx_t                   cfg_idx;

    logic [STAGES-1:0]          stage_vld_reg;
    logic                       out_vld_reg;
    stage_ctrl_t                ctrl;

    logic signed [SAMPLE_W-1:0] lane_off   [CHANNELS];
    logic [SAMPLE_W-1:0]        lane_floor [CHANNELS];
    logic [VAL_W-1:0]           lane_val   [CHANNELS];
    result_t                    result;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_ofs_reg   <= '0;
            bv_ofs_reg   <= '0;
            ic_floor_reg <= '0;
            lc_floor_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_CV_OFS:   cv_ofs_reg   <= pwdata[SAMPLE_W-1:0];
                REG_BV_OFS:   bv_ofs_reg   <= pwdata[SAMPLE_W-1:0];
                REG_IC_FLOOR: ic_floor_reg <= pwdata[SAMPLE_W-1:0];
                REG_LC_FLOOR: lc_floor_reg <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_CV_OFS:   prdata = DATA_W'(cv_ofs_reg);
            REG_BV_OFS:   prdata = DATA_W'(bv_ofs_reg);
            REG_IC_FLOOR: prdata = DATA_W'(ic_floor_reg);
            REG_LC_FLOOR: prdata = DATA_W'(lc_floor_reg);
            default:      prdata = '0;
        endcase
    end

    // whole pipeline moves whenever the output register can take a result
    assign ctrl.adv    = !out_vld_reg || m_tready;
    assign ctrl.accept = s_tvalid && ctrl.adv;
    assign s_tready    = ctrl.adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= '0;
            out_vld_reg   <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            stage_vld_reg <= {stage_vld_reg[STAGES-2:0], ctrl.accept};
            out_vld_reg   <= stage_vld_reg[STAGES-1];
        end
    end

    // per-lane configuration
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            lane_off[i]   = '0;
            lane_floor[i] = '0;
        end
        lane_off[CH_CV]   = cv_ofs_reg;
        lane_off[CH_BV]   = bv_ofs_reg;
        lane_floor[CH_IC] = ic_floor_reg;
        lane_floor[CH_LA] = lc_floor_reg;
        lane_floor[CH_LB] = lc_floor_reg;
    end

    // one averaging and calibration lane per converter channel
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        adcac_lane #(
            .WINDOW_LEN (WINDOW_LEN),
            .LANE_MODE  (LANE_MODES[g])
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample     (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .cfg_offset (lane_off[g]),
            .cfg_floor  (lane_floor[g]),
            .value      (lane_val[g])
        );
    end

    adcac_merge u_merge (
        .clk      (clk),
        .adv      (ctrl.adv),
        .lane_val (lane_val),
        .result   (result)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = result;

    // a held result stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // an accepted request enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> stage_vld_reg[0])
        else $error("accepted request lost at first stage");

    // a result appears only from the last pipeline stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(stage_vld_reg[STAGES-1]))
        else $error("result without request in last stage");

    // a stall freezes the stage valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(stage_vld_reg))
        else $error("pipeline moved during stall");

endmodule
